### sv/ecefenu_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the ECEF/ENU rotation.
// No dependencies; every other file of the block imports this package.
package ecefenu_pkg;

    // Default arithmetic settings
    localparam int TRIG_FRAC_BITS_DEF    = 30;
    localparam int CORDIC_ITERATIONS_DEF = 32;
    localparam int ATAN_DEPTH            = 48;
    localparam int ATAN_IW               = 6;

    // Field widths
    localparam int VEC_W = 40;
    localparam int REF_W = 34;
    localparam int ANG_W = 32;
    localparam int DIF_W = 41;
    localparam int LO_W  = 21;
    localparam int HI_W  = DIF_W - LO_W;
    localparam int CFG_IW = 3;

    // CORDIC constants: gain in Q62, 1/pi in Q64
    localparam logic [63:0]  GAIN_Q62  = 64'd2800459870029452954;
    localparam logic [63:0]  INVPI_Q64 = 64'h517CC1B727220A95;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_Z   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LAT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_LON = 3'd4;

    // Input mode codes
    localparam logic MODE_TO_ENU  = 1'b0;
    localparam logic MODE_TO_ECEF = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [VEC_W-1:0] vec_a;
        logic signed [VEC_W-1:0] vec_b;
        logic signed [VEC_W-1:0] vec_c;
    } t_in;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_a;
        logic signed [VEC_W-1:0] out_b;
        logic signed [VEC_W-1:0] out_c;
    } t_out;

    typedef logic signed [63:0] t_atan_tab [ATAN_DEPTH];

    // atan(2^-i)/pi in 2^-62 semicircles: Taylor series in Q62 radians times 1/pi
    function automatic t_atan_tab f_atan_tab();
        t_atan_tab    tab;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        logic         stop;
        int           d;
        for (int i = 0; i < ATAN_DEPTH; i++) begin
            if (i == 0) begin
                tab[i] = 64'sd1 <<< 60;
            end else begin
                sum  = '0;
                stop = 1'b0;
                for (int k = 0; k < 64; k++) begin
                    d = 2 * k + 1;
                    if (!stop && (i * d > 62)) stop = 1'b1;
                    if (!stop) begin
                        term = (64'd1 << (62 - i * d)) / 64'(d);
                        if (term == 64'd0) begin
                            stop = 1'b1;
                        end else if (k % 2 == 1) begin
                            sum = sum - term;
                        end else begin
                            sum = sum + term;
                        end
                    end
                end
                prod   = {64'd0, sum} * {64'd0, INVPI_Q64};
                tab[i] = prod[127:64];
            end
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = f_atan_tab();

endpackage

### sv/ecefenu_cordic.sv
// Iterative rotation-mode CORDIC for one angle, one iteration per cycle while i_step is high.
// Depends on ecefenu_pkg (gain, arctangent table).
module ecefenu_cordic #(
    parameter int TRIG_FRAC_BITS    = ecefenu_pkg::TRIG_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = ecefenu_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic                                   i_step,
    input  logic [ecefenu_pkg::ANG_W-1:0]          i_ang,
    input  logic [$clog2(CORDIC_ITERATIONS)-1:0]   i_iter,
    output logic signed [TRIG_FRAC_BITS+2:0]       o_sin,
    output logic signed [TRIG_FRAC_BITS+2:0]       o_cos
);
    import ecefenu_pkg::*;

    localparam int CW = TRIG_FRAC_BITS + 3;
    localparam int SH = 62 - TRIG_FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);

    logic signed [63:0] r_x, r_y, r_z;
    logic [1:0]         r_q;
    logic signed [63:0] xs, ys, atan_i;
    logic signed [63:0] xr, yr;
    logic signed [CW-1:0] cr, sr;

    // Load the start vector or rotate by one step
    always_comb begin
        xs     = r_x >>> i_iter;
        ys     = r_y >>> i_iter;
        atan_i = ATAN_TAB[ATAN_IW'(i_iter)];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= $signed(GAIN_Q62);
            r_y <= '0;
            r_z <= $signed({33'd0, i_ang[29:0], 1'b0}) <<< 30;
            r_q <= i_ang[31:30];
        end else if (i_step) begin
            if (!r_z[63]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_i;
            end
        end
    end

    // Round to the trig format and apply the quadrant
    always_comb begin
        xr = (r_x + HALF) >>> SH;
        yr = (r_y + HALF) >>> SH;
        cr = xr[CW-1:0];
        sr = yr[CW-1:0];
        case (r_q)
            2'd1: begin
                o_sin = cr;
                o_cos = -sr;
            end
            2'd2: begin
                o_sin = -sr;
                o_cos = -cr;
            end
            2'd3: begin
                o_sin = -cr;
                o_cos = sr;
            end
            default: begin
                o_sin = sr;
                o_cos = cr;
            end
        endcase
    end

endmodule

### sv/ecefenu_trig.sv
// Sequencer that builds the 3x3 rotation matrix from latitude and longitude.
// Depends on ecefenu_pkg and ecefenu_cordic.
module ecefenu_trig #(
    parameter int TRIG_FRAC_BITS    = ecefenu_pkg::TRIG_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = ecefenu_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [ecefenu_pkg::ANG_W-1:0]        i_lat,
    input  logic [ecefenu_pkg::ANG_W-1:0]        i_lon,
    output logic                                 o_valid,
    output logic [8:0][TRIG_FRAC_BITS+2:0]       o_coef
);
    import ecefenu_pkg::*;

    localparam int CW  = TRIG_FRAC_BITS + 3;
    localparam int NW  = $clog2(CORDIC_ITERATIONS);
    localparam logic [NW-1:0] LAST = NW'(CORDIC_ITERATIONS - 1);
    localparam logic signed [2*CW-1:0] HALF = (2*CW)'(1) <<< (TRIG_FRAC_BITS - 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [NW-1:0] r_cnt;
    logic [1:0]    r_pcnt;

    logic signed [CW-1:0] lat_s, lat_c, lon_s, lon_c;
    logic signed [CW-1:0] r_sla, r_cla, r_slo, r_clo;
    logic signed [CW-1:0] r_t [4];
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [2*CW-1:0] prod;

    ecefenu_cordic #(
        .TRIG_FRAC_BITS    (TRIG_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_lat (
        .i_clk  (i_clk),
        .i_load (r_state == ST_LOAD),
        .i_step (r_state == ST_RUN),
        .i_ang  (i_lat),
        .i_iter (r_cnt),
        .o_sin  (lat_s),
        .o_cos  (lat_c)
    );

    ecefenu_cordic #(
        .TRIG_FRAC_BITS    (TRIG_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_lon (
        .i_clk  (i_clk),
        .i_load (r_state == ST_LOAD),
        .i_step (r_state == ST_RUN),
        .i_ang  (i_lon),
        .i_iter (r_cnt),
        .o_sin  (lon_s),
        .o_cos  (lon_c)
    );

    // Next state: restart on any angle write
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:  n_state = ST_RUN;
            ST_RUN:   if (r_cnt == LAST) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_MUL;
            ST_MUL:   if (r_pcnt == 2'd3) n_state = ST_DONE;
            ST_DONE:  n_state = ST_DONE;
            default:  n_state = ST_LOAD;
        endcase
        if (i_start) n_state = ST_LOAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_pcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == ST_RUN) ? r_cnt + 1'b1 : '0;
            r_pcnt  <= (r_state == ST_MUL) ? r_pcnt + 2'd1 : 2'd0;
        end
    end

    // Shared multiplier for the four latitude/longitude products
    always_comb begin
        mul_a = r_pcnt[1] ? r_cla : r_sla;
        mul_b = r_pcnt[0] ? r_slo : r_clo;
        prod  = (mul_a * mul_b + HALF) >>> TRIG_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            r_sla <= lat_s;
            r_cla <= lat_c;
            r_slo <= lon_s;
            r_clo <= lon_c;
        end
        if (r_state == ST_MUL) begin
            r_t[r_pcnt] <= prod[CW-1:0];
        end
    end

    // Matrix rows: east, north, up
    assign o_valid   = (r_state == ST_DONE);
    assign o_coef[0] = -r_slo;
    assign o_coef[1] = r_clo;
    assign o_coef[2] = '0;
    assign o_coef[3] = -r_t[0];
    assign o_coef[4] = -r_t[1];
    assign o_coef[5] = r_cla;
    assign o_coef[6] = r_t[2];
    assign o_coef[7] = r_t[3];
    assign o_coef[8] = r_sla;

endmodule

### sv/ecef_enu_rotation.sv
// ECEF <-> ENU rotation: one item per cycle while the output is not stalled and the matrix
// is built; stages are subtract, split multiply, product merge, sum, round/saturate.
// After reset and after each latitude or longitude write, input ready stays low
// while the CORDIC and the shared multiplier rebuild the matrix.
// Reset is synchronous, active low; reference registers reset to zero.
module ecef_enu_rotation #(
    parameter int TRIG_FRAC_BITS    = ecefenu_pkg::TRIG_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = ecefenu_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ecefenu_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [ecefenu_pkg::REF_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ecefenu_pkg::t_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ecefenu_pkg::t_out                 o_out_data
);
    import ecefenu_pkg::*;

    localparam int CW  = TRIG_FRAC_BITS + 3;
    localparam int LPW = CW + LO_W + 1;
    localparam int HPW = CW + HI_W;
    localparam int PW  = CW + DIF_W;
    localparam int AW  = PW + 2;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] OMAX = AW'((64'd1 << (VEC_W - 1)) - 64'd1);
    localparam logic signed [AW-1:0] OMIN = -OMAX - AW'(1);

    logic [REF_W-1:0] r_ref [3];
    logic [ANG_W-1:0] r_lat, r_lon;

    logic                  trig_valid;
    logic [8:0][CW-1:0]    coef;
    logic                  en;

    logic                         r_v1, r_v2, r_v3, r_v4, r_ov;
    logic                         r_m1, r_m2, r_m3;
    logic signed [DIF_W-1:0]      r_d1 [3];
    logic signed [LPW-1:0]        r_lo [3][3];
    logic signed [HPW-1:0]        r_hi [3][3];
    logic signed [PW-1:0]         r_p  [3][3];
    logic signed [AW-1:0]         r_acc [3];
    logic signed [VEC_W-1:0]      r_out [3];

    logic signed [VEC_W-1:0]      vin [3];
    logic signed [CW-1:0]         csel [3][3];
    logic signed [AW-1:0]         n_acc [3];
    logic signed [AW-1:0]         shr [3];

    // Configuration registers; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref[0] <= '0;
            r_ref[1] <= '0;
            r_ref[2] <= '0;
            r_lat    <= '0;
            r_lon    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X:   r_ref[0] <= i_cfg_data;
                REG_Y:   r_ref[1] <= i_cfg_data;
                REG_Z:   r_ref[2] <= i_cfg_data;
                REG_LAT: r_lat    <= i_cfg_data[ANG_W-1:0];
                REG_LON: r_lon    <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    ecefenu_trig #(
        .TRIG_FRAC_BITS    (TRIG_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we && (i_cfg_idx == REG_LAT || i_cfg_idx == REG_LON)),
        .i_lat   (r_lat),
        .i_lon   (r_lon),
        .o_valid (trig_valid),
        .o_coef  (coef)
    );

    // Advance the whole pipe unless the output item is stuck
    assign en         = !r_ov || i_out_ready;
    assign o_in_ready = en && trig_valid;

    always_comb begin
        vin[0] = i_in_data.vec_a;
        vin[1] = i_in_data.vec_b;
        vin[2] = i_in_data.vec_c;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                csel[j][k] = (r_m1 == MODE_TO_ECEF) ? $signed(coef[k*3+j])
                                                    : $signed(coef[j*3+k]);
            end
        end
        for (int j = 0; j < 3; j++) begin
            n_acc[j] = AW'(r_p[j][0]) + AW'(r_p[j][1]) + AW'(r_p[j][2]) + HALF;
            if (r_m3 == MODE_TO_ECEF) begin
                n_acc[j] = n_acc[j] + (AW'($signed(r_ref[j])) <<< TRIG_FRAC_BITS);
            end
            shr[j] = r_acc[j] >>> TRIG_FRAC_BITS;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid && o_in_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    // Payload stages: subtract (to ENU), split multiply, merge, sum (plus reference to ECEF), round and saturate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= i_in_data.mode;
            for (int k = 0; k < 3; k++) begin
                r_d1[k] <= (i_in_data.mode == MODE_TO_ECEF) ? DIF_W'(vin[k])
                         : DIF_W'(vin[k]) - DIF_W'($signed(r_ref[k]));
            end
            r_m2 <= r_m1;
            r_m3 <= r_m2;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[j][k] <= csel[j][k] * $signed({1'b0, r_d1[k][LO_W-1:0]});
                    r_hi[j][k] <= csel[j][k] * $signed(r_d1[k][DIF_W-1:LO_W]);
                    r_p[j][k]  <= (PW'(r_hi[j][k]) <<< LO_W) + PW'(r_lo[j][k]);
                end
                r_acc[j] <= n_acc[j];
                if (shr[j] > OMAX) begin
                    r_out[j] <= OMAX[VEC_W-1:0];
                end else if (shr[j] < OMIN) begin
                    r_out[j] <= OMIN[VEC_W-1:0];
                end else begin
                    r_out[j] <= shr[j][VEC_W-1:0];
                end
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_data.out_a = r_out[0];
    assign o_out_data.out_b = r_out[1];
    assign o_out_data.out_c = r_out[2];

    // Items enter only with a finished matrix
    a_ready_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> trig_valid)
        else $error("input ready while matrix not built");

    // An angle write blocks input on the next cycle
    a_angle_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_LAT || i_cfg_idx == REG_LON)) |=> !o_in_ready)
        else $error("input accepted during matrix rebuild");

    // A stalled pipe keeps the stage before the output
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready && r_v4) |=> (r_v4 && $stable(r_acc[0])))
        else $error("stage lost during stall");

endmodule
